### hdl/lpm_pkg.sv
// ============================================================================
// lpm_pkg
// Shared types and constants for the IPv4 longest prefix match trie.
// ============================================================================
`default_nettype none

package lpm_pkg;

    localparam int NODE_COUNT = 65536;
    localparam int NODE_W     = $clog2(NODE_COUNT);

    localparam int ADDR_W     = 32;
    localparam int HOP_W      = 32;
    localparam int PLEN_W     = 6;
    localparam int DEPTH_W    = 6;

    // stream payload widths; the data widths are padded to whole bytes
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 40;

    localparam logic [NODE_W-1:0]  ROOT_NODE = NODE_W'(1);
    localparam logic [NODE_W-1:0]  NODE_LAST = NODE_W'(NODE_COUNT - 1);
    localparam logic [PLEN_W-1:0]  PLEN_MAX  = PLEN_W'(32);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(32);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // one trie node as held in the node memory
    typedef struct packed {
        logic              has_hop;
        logic [NODE_W-1:0] child_one;
        logic [NODE_W-1:0] child_zero;
    } t_node_word;

    localparam int NODE_WORD_W = $bits(t_node_word);

endpackage

`default_nettype wire

### hdl/lpm_ram.sv
// ============================================================================
// lpm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/ipv4_longest_prefix_match.sv
// Sequence: an insert walks the trie and writes the hop at the final node; a default-route
//   insert skips it. A lookup walks the trie, then reads the hop memory if a route matched.
// Flow: one transaction at a time, a new one taken only in the idle state; the bound is
//   the node memory, one read per trie level with the next address taken from its data.
// Reset: synchronous, active low; clears control, the pool counter and the default route.
//   No clearing pass: the root is masked until first written, other nodes are written
//   whole when allocated.
// ============================================================================
// ipv4_longest_prefix_match
// Binary trie routing table: route insert and longest prefix lookup.
// ============================================================================
`default_nettype none

module ipv4_longest_prefix_match
    import lpm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // slave side: requests
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] address, [37:32] prefix_len, [69:38] next_hop, [71:70] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] operation
    input  wire logic [S_USER_W-1:0] s_tuser,
    // master side: results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [31:0] hop_result, [32] status, [39:33] zero
    output logic      [M_DATA_W-1:0] m_tdata
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a transaction
    localparam logic [1:0] S_WALK = 2'd1;   // one trie level per cycle
    localparam logic [1:0] S_HOP  = 2'd2;   // hop memory read returns
    localparam logic [1:0] S_OUT  = 2'd3;   // hand result to output register

    logic [1:0]          r_state, n_state;
    logic                r_op, n_op;
    logic [ADDR_W-1:0]   r_bits, n_bits;       // address, shifted left per level
    logic [PLEN_W-1:0]   r_plen, n_plen;
    logic [HOP_W-1:0]    r_hop_in, n_hop_in;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [NODE_W-1:0]   r_node, n_node;
    logic                r_fresh, n_fresh;     // current node just allocated
    logic                r_best_ok, n_best_ok;
    logic [NODE_W-1:0]   r_best, n_best;
    logic [NODE_W-1:0]   r_free, n_free;       // last allocated node
    logic [HOP_W-1:0]    r_default, n_default;
    logic                r_root_ok, n_root_ok; // root written since reset
    logic [HOP_W-1:0]    r_res_hop, n_res_hop;
    logic                r_res_st, n_res_st;
    logic                r_ov, n_ov;
    logic [HOP_W:0]      r_m_data, n_m_data;

    // memory ports
    logic                node_we, node_re;
    logic [NODE_W-1:0]   node_waddr, node_raddr;
    t_node_word          node_wdata;
    logic [NODE_WORD_W-1:0] node_rdata;
    logic                hop_we, hop_re;
    logic [NODE_W-1:0]   hop_waddr, hop_raddr;
    logic [HOP_W-1:0]    hop_wdata, hop_rdata;

    // input fields
    logic                in_op;
    logic [ADDR_W-1:0]   in_addr;
    logic [PLEN_W-1:0]   in_plen, in_plen_sat;
    logic [HOP_W-1:0]    in_hop;

    // current node view
    t_node_word          w;
    logic [NODE_W-1:0]   child;
    logic                best_ok_now;
    logic [NODE_W-1:0]   best_now;
    logic [NODE_W-1:0]   new_node;

    assign in_op   = s_tuser[0];
    assign in_addr = s_tdata[31:0];
    assign in_plen = s_tdata[37:32];
    assign in_hop  = s_tdata[69:38];
    assign in_plen_sat = (in_plen > PLEN_MAX) ? PLEN_MAX : in_plen;

    // A fresh node and an unwritten root both read as empty.
    always_comb begin
        if (r_fresh || (r_node == ROOT_NODE && !r_root_ok)) begin
            w = '0;
        end else begin
            w = t_node_word'(node_rdata);
        end
    end

    assign child       = r_bits[ADDR_W-1] ? w.child_one : w.child_zero;
    assign best_ok_now = r_best_ok | w.has_hop;
    assign best_now    = w.has_hop ? r_node : r_best;
    assign new_node    = r_free + NODE_W'(1);

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ov;
    assign m_tdata  = {{(M_DATA_W - HOP_W - 1){1'b0}}, r_m_data};

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_bits    = r_bits;
        n_plen    = r_plen;
        n_hop_in  = r_hop_in;
        n_depth   = r_depth;
        n_node    = r_node;
        n_fresh   = r_fresh;
        n_best_ok = r_best_ok;
        n_best    = r_best;
        n_free    = r_free;
        n_default = r_default;
        n_root_ok = r_root_ok;
        n_res_hop = r_res_hop;
        n_res_st  = r_res_st;
        n_ov      = r_ov && !m_tready;
        n_m_data  = r_m_data;

        node_we    = 1'b0;
        node_waddr = r_node;
        node_wdata = w;
        node_re    = 1'b0;
        node_raddr = child;
        hop_we     = 1'b0;
        hop_waddr  = r_node;
        hop_wdata  = r_hop_in;
        hop_re     = 1'b0;
        hop_raddr  = best_now;

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_op      = in_op;
                    n_bits    = in_addr;
                    n_plen    = in_plen_sat;
                    n_hop_in  = in_hop;
                    n_depth   = '0;
                    n_node    = ROOT_NODE;
                    n_fresh   = 1'b0;
                    n_best_ok = 1'b0;
                    n_best    = ROOT_NODE;
                    if (in_op == OP_INSERT && in_addr == '0) begin
                        // default route, trie untouched
                        n_default = in_hop;
                        n_res_hop = '0;
                        n_res_st  = ST_OK;
                        n_state   = S_OUT;
                    end else begin
                        node_re    = 1'b1;
                        node_raddr = ROOT_NODE;
                        n_state    = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (r_op == OP_LOOKUP) begin
                    n_best_ok = best_ok_now;
                    n_best    = best_now;
                    if (r_depth == DEPTH_MAX || child == '0) begin
                        if (best_ok_now) begin
                            hop_re  = 1'b1;
                            n_state = S_HOP;
                        end else begin
                            n_res_hop = r_default;
                            n_state   = S_OUT;
                        end
                        n_res_st = ST_OK;
                    end else begin
                        node_re = 1'b1;
                        n_node  = child;
                        n_depth = r_depth + DEPTH_W'(1);
                        n_bits  = r_bits << 1;
                    end
                end else begin
                    if (r_depth == r_plen) begin
                        // final node: store the hop
                        node_we            = 1'b1;
                        node_wdata.has_hop = 1'b1;
                        hop_we             = 1'b1;
                        n_res_hop          = '0;
                        n_res_st           = ST_OK;
                        n_state            = S_OUT;
                    end else if (child != '0) begin
                        node_re = 1'b1;
                        n_node  = child;
                        n_fresh = 1'b0;
                        n_depth = r_depth + DEPTH_W'(1);
                        n_bits  = r_bits << 1;
                    end else if (r_free == NODE_LAST) begin
                        // pool exhausted; a fresh node still gets its empty word
                        node_we   = 1'b1;
                        n_res_hop = '0;
                        n_res_st  = ST_FULL;
                        n_state   = S_OUT;
                    end else begin
                        node_we = 1'b1;
                        if (r_bits[ADDR_W-1]) begin
                            node_wdata.child_one = new_node;
                        end else begin
                            node_wdata.child_zero = new_node;
                        end
                        n_free  = new_node;
                        n_node  = new_node;
                        n_fresh = 1'b1;
                        n_depth = r_depth + DEPTH_W'(1);
                        n_bits  = r_bits << 1;
                    end
                end
            end

            S_HOP: begin
                n_res_hop = hop_rdata;
                n_state   = S_OUT;
            end

            S_OUT: begin
                if (!r_ov || m_tready) begin
                    n_ov     = 1'b1;
                    n_m_data = {r_res_st, r_res_hop};
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (node_we && node_waddr == ROOT_NODE) begin
            n_root_ok = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= ROOT_NODE;
            r_default <= '0;
            r_root_ok <= 1'b0;
            r_ov      <= 1'b0;
            r_fresh   <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_default <= n_default;
            r_root_ok <= n_root_ok;
            r_ov      <= n_ov;
            r_fresh   <= n_fresh;
            r_best_ok <= n_best_ok;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_bits    <= n_bits;
        r_plen    <= n_plen;
        r_hop_in  <= n_hop_in;
        r_depth   <= n_depth;
        r_node    <= n_node;
        r_best    <= n_best;
        r_res_hop <= n_res_hop;
        r_res_st  <= n_res_st;
        r_m_data  <= n_m_data;
    end

    // child links and hop flag per node
    lpm_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // stored next hops, read only where the hop flag is set
    lpm_ram #(
        .WIDTH (HOP_W),
        .DEPTH (NODE_COUNT)
    ) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (hop_we),
        .i_waddr (hop_waddr),
        .i_wdata (hop_wdata),
        .i_re    (hop_re),
        .i_raddr (hop_raddr),
        .o_rdata (hop_rdata)
    );

endmodule

`default_nettype wire

### hdl/lpm_checker.sv
// ============================================================================
// lpm_checker
// Port-level assertions for the longest prefix match block.
// ============================================================================
`default_nettype none

module lpm_checker
    import lpm_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted back to back");

    // a full-pool status carries a zero hop; padding is checked below for every result
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[HOP_W] |-> m_tdata[HOP_W-1:0] == '0)
        else $error("nonzero hop with pool-full status");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:HOP_W+1] == '0)
        else $error("padding bits set in result");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (.*);

`default_nettype wire

### bench/ipv4_longest_prefix_match_tb.sv
// ============================================================================
// ipv4_longest_prefix_match_tb
// Self-checking bench for the trie routing table. Route inserts and lookups
// go in on the request stream. A behavioral trie predicts the answers, typed
// directed rows carry their own, and each answer is checked field by field, in
// order. The run starts with a short directed table. Random traffic follows
// under several idle and stall patterns.
// ============================================================================
`default_nettype none

module ipv4_longest_prefix_match_tb
    import lpm_pkg::*;
();

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 335;
    localparam int LEARNED_MAX      = 512;
    localparam int DIRECTED_ROWS    = 25;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // [31:0] address, [37:32] prefix_len, [69:38] next_hop, [71:70] zero
    logic [S_DATA_W-1:0] s_tdata;
    // [0] operation
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // [31:0] hop_result, [32] status, [39:33] zero
    logic [M_DATA_W-1:0] m_tdata;

    ipv4_longest_prefix_match uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct packed {
        logic [HOP_W-1:0] hop;
        logic             status;
    } t_route_answer;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
    } t_route;

    // one directed transaction; typed rows carry their answer inline
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [HOP_W-1:0]  hop;
        logic              typed;
        logic [HOP_W-1:0]  want_hop;
        logic              want_status;
    } t_probe;

    // shadow trie
    bit [NODE_W-1:0] trie_zero [NODE_COUNT];
    bit [NODE_W-1:0] trie_one  [NODE_COUNT];
    bit              trie_has  [NODE_COUNT];
    bit [HOP_W-1:0]  trie_hop  [NODE_COUNT];
    int unsigned     last_node = 32'(ROOT_NODE);
    bit [HOP_W-1:0]  default_route_hop = '0;

    t_route_answer answers_due [$];
    t_route        learned     [$];
    int            mismatches  = 0;
    int            cycles      = 0;
    int            sender_idle_pct   = 0;
    int            receiver_stall_pct = 0;

    t_probe directed [DIRECTED_ROWS] = '{
        // empty table answers zero
        '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0,         1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0,         1'b1, 32'h0,         ST_OK},
        // default route, all-ones hop
        '{OP_INSERT, 32'h0000_0000, 6'd8,  32'hFFFF_FFFF, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h1234_5678, 6'd0,  32'h0,         1'b1, 32'hFFFF_FFFF, ST_OK},
        '{OP_INSERT, 32'h0A00_0000, 6'd8,  32'h0A0A_0A0A, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0A12_3456, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // host bits set below the prefix
        '{OP_INSERT, 32'h0A0B_0C0D, 6'd16, 32'h1616_1616, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0A0B_9999, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0A0C_0000, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // full-length host route, zero hop
        '{OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // oversized prefix length saturates to a host route, replacing it
        '{OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h55AA_55AA, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // same prefix again overwrites the hop
        '{OP_INSERT, 32'h0A00_0000, 6'd8,  32'h0102_0304, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0A00_0001, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // nonzero address at /0 lands on the root and shadows the default
        '{OP_INSERT, 32'h8000_0001, 6'd0,  32'hC0A8_0001, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0A0B_0000, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        // zero address is always the default route, whatever the length
        '{OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0101_0101, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        '{OP_INSERT, 32'h0000_0001, 6'd33, 32'hDEAD_BEEF, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'h0000_0001, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK},
        '{OP_INSERT, 32'h8000_0000, 6'd1,  32'h0000_0007, 1'b1, 32'h0,         ST_OK},
        '{OP_LOOKUP, 32'hC000_0000, 6'd0,  32'h0,         1'b0, 32'h0,         ST_OK}
    };

    // ------------------------------------------------------------------------
    // trie predictor
    // ------------------------------------------------------------------------
    function automatic logic predict_insert(logic [ADDR_W-1:0] addr,
                                            logic [PLEN_W-1:0] plen,
                                            logic [HOP_W-1:0] hop);
        int                len;
        int                pos;
        int unsigned       node;
        int unsigned       nxt;
        logic [ADDR_W-1:0] prefix;
        logic              b;
        if (addr == '0) begin
            default_route_hop = hop;
            return ST_OK;
        end
        len    = (plen > PLEN_MAX) ? 32 : int'(plen);
        prefix = (len == 0) ? '0 : (addr & (32'hFFFF_FFFF << (32 - len)));
        node   = 32'(ROOT_NODE);
        for (pos = 31; pos >= 32 - len; pos--) begin
            b   = prefix[pos];
            nxt = 32'(b ? trie_one[node] : trie_zero[node]);
            if (nxt == 0) begin
                // pool exhausted: links made so far stay, no hop stored
                if (last_node + 1 >= NODE_COUNT)
                    return ST_FULL;
                last_node++;
                nxt = last_node;
                if (b)
                    trie_one[node] = NODE_W'(nxt);
                else
                    trie_zero[node] = NODE_W'(nxt);
            end
            node = nxt;
        end
        trie_hop[node] = hop;
        trie_has[node] = 1'b1;
        return ST_OK;
    endfunction

    function automatic logic [HOP_W-1:0] predict_lookup(logic [ADDR_W-1:0] addr);
        logic [HOP_W-1:0] best;
        int unsigned      node;
        int unsigned      nxt;
        int               pos;
        best = trie_has[ROOT_NODE] ? trie_hop[ROOT_NODE] : default_route_hop;
        node = 32'(ROOT_NODE);
        for (pos = 31; pos >= 0; pos--) begin
            nxt = 32'(addr[pos] ? trie_one[node] : trie_zero[node]);
            if (nxt == 0)
                break;
            node = nxt;
            if (trie_has[node])
                best = trie_hop[node];
        end
        return best;
    endfunction

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ipv4_longest_prefix_match_tb NOT OK");
            $finish;
        end
    end

    // result side: random backpressure, changed on the falling edge
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(1, 100) > receiver_stall_pct);
    end

    // result checker: every accepted answer against the oldest prediction
    always @(posedge i_clk) begin
        t_route_answer want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $error("result with nothing pending: m_tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = answers_due.pop_front();
                if (m_tdata[31:0] !== want.hop) begin
                    $error("hop_result: expected %h, got %h", want.hop, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[32] !== want.status) begin
                    $error("status: expected %b, got %b", want.status, m_tdata[32]);
                    mismatches++;
                end
                if (m_tdata[M_DATA_W-1:33] !== '0) begin
                    $error("pad: expected 0, got %h", m_tdata[M_DATA_W-1:33]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [PLEN_W-1:0] plen,
                                input logic [HOP_W-1:0] hop, input logic typed,
                                input logic [HOP_W-1:0] want_hop,
                                input logic want_status);
        t_route_answer ans;
        t_route        r;
        while ($urandom_range(1, 100) <= sender_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, hop, plen, addr};
        do @(posedge i_clk); while (!s_tready);
        // transaction accepted at this edge
        if (op == OP_INSERT) begin
            ans.hop    = '0;
            ans.status = predict_insert(addr, plen, hop);
            if (ans.status == ST_OK && addr != '0) begin
                r.addr = addr;
                r.plen = plen;
                if (learned.size() < LEARNED_MAX)
                    learned.insert(learned.size(), r);
                else
                    learned[$urandom_range(0, LEARNED_MAX - 1)] = r;
            end
        end else begin
            ans.hop    = predict_lookup(addr);
            ans.status = ST_OK;
        end
        if (typed) begin
            ans.hop    = want_hop;
            ans.status = want_status;
        end
        answers_due.insert(answers_due.size(), ans);
    endtask

    // drop valid and hold off until every answer is back
    task automatic settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: lookups aimed at learned routes,
    // inserts refining them, some default-route and oversized-length noise.
    task automatic random_item();
        int                r;
        t_route            k;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [HOP_W-1:0]  hop;
        logic              op;
        r    = $urandom_range(0, 99);
        hop  = $urandom();
        addr = $urandom();
        plen = PLEN_W'($urandom_range(0, 32));
        if (learned.size() != 0)
            k = learned[$urandom_range(0, learned.size() - 1)];
        else
            k = '{addr: addr, plen: plen};
        op = (r < 40) ? OP_INSERT : OP_LOOKUP;
        if (r < 4) begin
            addr = '0;
            plen = PLEN_W'($urandom_range(0, 63));
        end else if (r < 9)
            plen = PLEN_W'($urandom_range(33, 63));
        else if (r < 24) begin
            addr = k.addr ^ (ADDR_W'($urandom()) >> $urandom_range(1, 32));
        end else if (r < 40) begin
            if (r < 28)
                plen = PLEN_W'($urandom_range(24, 32));
        end else if (r < 80)
            addr = k.addr ^ (ADDR_W'($urandom()) >> $urandom_range(1, 32));
        else if (r < 84)
            addr = (r < 82) ? '0 : '1;
        if (r < 2)
            hop = (r == 0) ? '0 : '1;
        send_request(op, addr, plen, hop, 1'b0, '0, ST_OK);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int n;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].op, directed[i].addr, directed[i].plen,
                         directed[i].hop, directed[i].typed,
                         directed[i].want_hop, directed[i].want_status);
        settle();

        // no idling, sender idle 80%, receiver stalling 80%, both 35%
        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1) ? 80 : (phase == 3) ? 35 : 0;
            receiver_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 35 : 0;
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                random_item();
            settle();
        end

        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("ipv4_longest_prefix_match_tb OK");
        else
            $display("ipv4_longest_prefix_match_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
